### rtl/tcd_pkg.sv
package tcd_pkg;

  // design constants
  localparam int MaxAxes   = 6;
  localparam int TimeW     = 32;
  localparam int PosW      = 32;
  localparam int StepW     = 20;
  localparam int AxisW     = 3;
  localparam int IndexW    = 16;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 20;
  localparam int DiffW     = 33;
  // 1000000 = 15625 * 64: multiply by 15625, then shift by 6
  localparam int Pow5W     = 14;
  localparam int Pow2Sh    = 6;
  localparam int ProdW     = DiffW + Pow5W;
  localparam int NumW      = ProdW + Pow2Sh;
  localparam int CntW      = 6;
  localparam logic [Pow5W-1:0] Pow5 = 14'd15625;
  localparam logic [StepW-1:0] MinStepRst = 20'd10;
  localparam logic [AxisW-1:0] AxesRst = 3'd6;

  typedef enum logic [CfgIdxW-1:0] {
    RegMinStep = 2'd0,
    RegAxes    = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LnIdle,
    LnMul,
    LnDiv,
    LnSat
  } lane_state_e;

  typedef enum logic [3:0] {
    StIdle,
    StVel,
    StVelWait,
    StAcc,
    StAccWait,
    StEmitPrev,
    StShift,
    StTail,
    StTailWait,
    StEmitTail,
    StEmitLast,
    StEmitErr
  } tcd_state_e;

  typedef struct packed {
    logic [TimeW-1:0]  time_us;
    logic signed [PosW-1:0] pos_a0;
    logic signed [PosW-1:0] pos_a1;
    logic signed [PosW-1:0] pos_a2;
    logic signed [PosW-1:0] pos_a3;
    logic signed [PosW-1:0] pos_a4;
    logic signed [PosW-1:0] pos_a5;
    logic              last_point;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0] point_index;
    logic [AxisW-1:0]  axis_index;
    logic [TimeW-1:0]  fixed_time_us;
    logic signed [PosW-1:0] position_out;
    logic signed [PosW-1:0] velocity_out;
    logic signed [PosW-1:0] accel_out;
    logic              status;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic emit;
    logic acc_use;
  } emit_ctl_t;

endpackage

### rtl/tcd_if.sv
interface tcd_in_if;
  logic               valid;
  logic               ready;
  tcd_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcd_out_if;
  logic               valid;
  logic               ready;
  tcd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/tcd_lane.sv
module tcd_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tcd_pkg::DiffW-1:0]         diff_i,
  input  logic [tcd_pkg::TimeW-1:0]         span_i,
  output logic                              busy_o,
  output logic [tcd_pkg::PosW-1:0]          rate_o
);

  tcd_pkg::lane_state_e state_q, state_d;

  logic                          neg_q, zero_q, ovf_q;
  logic [tcd_pkg::DiffW-1:0]     mag_q;
  logic [tcd_pkg::TimeW-1:0]     span_q;
  logic [tcd_pkg::NumW-1:0]      num_q;
  logic [tcd_pkg::TimeW:0]       rem_q;
  logic [tcd_pkg::TimeW:0]       quo_q;
  logic [tcd_pkg::CntW-1:0]      cnt_q;
  logic [tcd_pkg::PosW-1:0]      rate_q;

  logic [tcd_pkg::ProdW-1:0]     prod;
  logic [tcd_pkg::TimeW:0]       trial;
  logic                          ge;
  logic                          big;
  logic [tcd_pkg::PosW-1:0]      sat;

  // magnitude times 15625, shift by 6 (times 64) applied when loading the dividend
  assign prod  = tcd_pkg::ProdW'(mag_q) * tcd_pkg::ProdW'(tcd_pkg::Pow5);
  // one restoring step per cycle
  assign trial = {rem_q[tcd_pkg::TimeW-1:0], num_q[tcd_pkg::NumW-1]};
  assign ge    = trial >= {1'b0, span_q};

  // truncated quotient saturated to the signed 32-bit range
  always_comb begin
    big = ovf_q | quo_q[tcd_pkg::TimeW];
    if (zero_q) begin
      sat = '0;
    end else if (!neg_q) begin
      sat = (big || quo_q[tcd_pkg::PosW-1]) ? {1'b0, {(tcd_pkg::PosW-1){1'b1}}}
                                            : quo_q[tcd_pkg::PosW-1:0];
    end else if (big || (quo_q[tcd_pkg::PosW-1] && (quo_q[tcd_pkg::PosW-2:0] != '0))) begin
      sat = {1'b1, {(tcd_pkg::PosW-1){1'b0}}};
    end else begin
      sat = ~quo_q[tcd_pkg::PosW-1:0] + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcd_pkg::LnIdle: if (start_i) state_d = tcd_pkg::LnMul;
      tcd_pkg::LnMul:  state_d = tcd_pkg::LnDiv;
      tcd_pkg::LnDiv:  if (cnt_q == tcd_pkg::CntW'(tcd_pkg::NumW - 1)) state_d = tcd_pkg::LnSat;
      tcd_pkg::LnSat:  state_d = tcd_pkg::LnIdle;
      default:         state_d = tcd_pkg::LnIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcd_pkg::LnIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      tcd_pkg::LnIdle: begin
        if (start_i) begin
          neg_q  <= diff_i[tcd_pkg::DiffW-1];
          zero_q <= (diff_i == '0);
          mag_q  <= diff_i[tcd_pkg::DiffW-1] ? (~diff_i + 1'b1) : diff_i;
          span_q <= span_i;
        end
      end
      tcd_pkg::LnMul: begin
        num_q <= {prod, {tcd_pkg::Pow2Sh{1'b0}}};
        rem_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
        cnt_q <= '0;
      end
      tcd_pkg::LnDiv: begin
        rem_q <= ge ? (trial - {1'b0, span_q}) : trial;
        num_q <= {num_q[tcd_pkg::NumW-2:0], 1'b0};
        ovf_q <= ovf_q | quo_q[tcd_pkg::TimeW];
        quo_q <= {quo_q[tcd_pkg::TimeW-1:0], ge};
        cnt_q <= cnt_q + 1'b1;
      end
      tcd_pkg::LnSat: rate_q <= sat;
      default: ;
    endcase
  end

  assign busy_o = (state_q != tcd_pkg::LnIdle);
  assign rate_o = rate_q;

endmodule

### rtl/tcd_merge.sv
module tcd_merge #(
  parameter int NumAxes = tcd_pkg::MaxAxes
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tcd_pkg::emit_ctl_t        ctl_i,
  input  tcd_pkg::out_item_t        item_i,
  input  logic [tcd_pkg::PosW-1:0]  rate_i [NumAxes],
  output logic                      take_o,
  tcd_out_if.source                 out_o
);

  localparam int AxW = (NumAxes > 1) ? $clog2(NumAxes) : 1;

  logic               valid_q;
  tcd_pkg::out_item_t data_q;
  tcd_pkg::out_item_t merged;

  // pick the lane result of the emitted axis
  always_comb begin
    merged = item_i;
    merged.accel_out = ctl_i.acc_use ? rate_i[item_i.axis_index[AxW-1:0]] : '0;
  end

  assign take_o = ctl_i.emit && (!valid_q || out_o.ready);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) data_q <= merged;
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

endmodule

### rtl/trajectory_central_difference.sv
// Trajectory derivative block: velocity and acceleration by central differences.
// in_i takes one trajectory point per transfer (time, six positions, last flag).
// out_o gives one transfer per axis in use for each emitted point, axis 0 first.
// A point is emitted once the second point after it has arrived; the point marked
// last flushes the two pending points. A last point with nothing before it
// gives a single transfer with status 1.
// cfg_we_i / cfg_idx_i / cfg_data_i write min_time_step (0) and axes_in_use (1)
// between trajectories; reset loads 10 us and 6 axes and empties the stream.
// Each lane divides with a restoring divider, one quotient bit per cycle;
// all axes divide in parallel. An inner point costs one velocity and one
// acceleration pass followed by the transfers of the point it emits; the last
// point adds one more pass and the transfers of the two flushed points.
// in_i is ready only between points. Results sit in an output register; a
// stalled receiver holds the sequencer at the next transfer, and the block
// takes the next point while the final result still waits to be taken.
module trajectory_central_difference #(
  parameter int NumAxes = tcd_pkg::MaxAxes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tcd_in_if.sink                       in_i,
  tcd_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [tcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcd_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int AxW = (NumAxes > 1) ? $clog2(NumAxes) : 1;
  localparam int TW  = tcd_pkg::TimeW;
  localparam int PW  = tcd_pkg::PosW;

  tcd_pkg::tcd_state_e state_q, state_d;

  logic [tcd_pkg::StepW-1:0]  step_q;
  logic [tcd_pkg::AxisW-1:0]  axes_q;

  logic [TW-1:0]          tw_q [3];
  logic [PW-1:0]          pw_q [3][NumAxes];
  logic [PW-1:0]          vw_q [2][NumAxes];
  logic [PW-1:0]          pin_q [NumAxes];
  logic [PW-1:0]          vnew_q [NumAxes];
  logic [TW-1:0]          ft_q;
  logic                   last_q;
  logic                   acc_use_q;
  logic [1:0]             n_q;
  logic [tcd_pkg::IndexW-1:0] eidx_q;
  logic [tcd_pkg::AxisW-1:0]  ax_q;

  logic [PW-1:0]          pin_w [tcd_pkg::MaxAxes];
  logic [TW:0]            lo;
  logic [TW-1:0]          ft_w;
  logic [tcd_pkg::AxisW-1:0] na;
  logic                   accept;
  logic                   take;
  logic                   ax_end;
  logic                   start;
  logic [TW-1:0]          span;
  logic [tcd_pkg::DiffW-1:0] diff [NumAxes];
  logic [PW-1:0]          rate [NumAxes];
  logic [NumAxes-1:0]     busy;
  tcd_pkg::emit_ctl_t     ctl;
  tcd_pkg::out_item_t     item;

  assign pin_w[0] = in_i.data.pos_a0;
  assign pin_w[1] = in_i.data.pos_a1;
  assign pin_w[2] = in_i.data.pos_a2;
  assign pin_w[3] = in_i.data.pos_a3;
  assign pin_w[4] = in_i.data.pos_a4;
  assign pin_w[5] = in_i.data.pos_a5;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= tcd_pkg::MinStepRst;
      axes_q <= tcd_pkg::AxesRst;
    end else if (cfg_we_i) begin
      case (tcd_pkg::cfg_reg_e'(cfg_idx_i))
        tcd_pkg::RegMinStep: step_q <= cfg_data_i;
        tcd_pkg::RegAxes:    axes_q <= cfg_data_i[tcd_pkg::AxisW-1:0];
        default: ;
      endcase
    end
  end

  // axes actually emitted
  always_comb begin
    if (axes_q == '0) na = 3'd1;
    else if (axes_q > tcd_pkg::AxisW'(NumAxes)) na = tcd_pkg::AxisW'(NumAxes);
    else na = axes_q;
  end

  // time correction: at least one step after the previous corrected time
  always_comb begin
    lo = {1'b0, tw_q[2]} + (TW + 1)'(step_q);
    if (lo[TW]) lo = {1'b0, {TW{1'b1}}};
    if (n_q == 2'd0) ft_w = in_i.data.time_us;
    else ft_w = (in_i.data.time_us > lo[TW-1:0]) ? in_i.data.time_us : lo[TW-1:0];
  end

  assign in_i.ready = (state_q == tcd_pkg::StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign ax_end     = (ax_q == na - 1'b1);

  // lane operands for each division pass
  assign start = (state_q == tcd_pkg::StVel) || (state_q == tcd_pkg::StAcc) ||
                 (state_q == tcd_pkg::StTail);
  assign span  = (state_q == tcd_pkg::StVel) ? (ft_q - tw_q[1]) : (tw_q[2] - tw_q[0]);

  for (genvar l = 0; l < NumAxes; l++) begin : g_lane
    always_comb begin
      case (state_q)
        tcd_pkg::StVel:
          diff[l] = {pin_q[l][PW-1], pin_q[l]} - {pw_q[1][l][PW-1], pw_q[1][l]};
        tcd_pkg::StAcc:
          diff[l] = {vnew_q[l][PW-1], vnew_q[l]} - {vw_q[0][l][PW-1], vw_q[0][l]};
        default:
          diff[l] = '0 - {vw_q[0][l][PW-1], vw_q[0][l]};
      endcase
    end

    tcd_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start),
      .diff_i  (diff[l]),
      .span_i  (span),
      .busy_o  (busy[l]),
      .rate_o  (rate[l])
    );
  end

  // next state and emitted item
  always_comb begin
    state_d     = state_q;
    ctl.emit    = 1'b0;
    ctl.acc_use = 1'b0;
    item.point_index   = eidx_q;
    item.axis_index    = ax_q;
    item.fixed_time_us = tw_q[1];
    item.position_out  = pw_q[1][ax_q[AxW-1:0]];
    item.velocity_out  = vw_q[1][ax_q[AxW-1:0]];
    item.accel_out     = '0;
    item.status        = 1'b0;
    item.last_result   = 1'b0;
    case (state_q)
      tcd_pkg::StIdle: begin
        if (accept) begin
          if (in_i.data.last_point && (n_q == 2'd0)) state_d = tcd_pkg::StEmitErr;
          else if (n_q >= 2'd2) state_d = tcd_pkg::StVel;
          else state_d = tcd_pkg::StShift;
        end
      end
      tcd_pkg::StVel: state_d = tcd_pkg::StVelWait;
      tcd_pkg::StVelWait: begin
        if (busy == '0) state_d = (n_q == 2'd3) ? tcd_pkg::StAcc : tcd_pkg::StEmitPrev;
      end
      tcd_pkg::StAcc: state_d = tcd_pkg::StAccWait;
      tcd_pkg::StAccWait: if (busy == '0) state_d = tcd_pkg::StEmitPrev;
      tcd_pkg::StEmitPrev: begin
        ctl.emit    = 1'b1;
        ctl.acc_use = acc_use_q;
        if (take && ax_end) state_d = tcd_pkg::StShift;
      end
      tcd_pkg::StShift: begin
        if (!last_q) state_d = tcd_pkg::StIdle;
        else if (n_q >= 2'd2) state_d = tcd_pkg::StTail;
        else state_d = tcd_pkg::StEmitTail;
      end
      tcd_pkg::StTail: state_d = tcd_pkg::StTailWait;
      tcd_pkg::StTailWait: if (busy == '0) state_d = tcd_pkg::StEmitTail;
      tcd_pkg::StEmitTail: begin
        ctl.emit    = 1'b1;
        ctl.acc_use = acc_use_q;
        if (take && ax_end) state_d = tcd_pkg::StEmitLast;
      end
      tcd_pkg::StEmitLast: begin
        ctl.emit           = 1'b1;
        item.fixed_time_us = ft_q;
        item.position_out  = pin_q[ax_q[AxW-1:0]];
        item.velocity_out  = '0;
        item.last_result   = ax_end;
        if (take && ax_end) state_d = tcd_pkg::StIdle;
      end
      tcd_pkg::StEmitErr: begin
        ctl.emit           = 1'b1;
        item.point_index   = '0;
        item.axis_index    = '0;
        item.fixed_time_us = '0;
        item.position_out  = '0;
        item.velocity_out  = '0;
        item.status        = 1'b1;
        item.last_result   = 1'b1;
        if (take) state_d = tcd_pkg::StIdle;
      end
      default: state_d = tcd_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcd_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // stream control: point count, emit index, axis counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      eidx_q <= '0;
      ax_q   <= '0;
    end else if (take && ((state_q == tcd_pkg::StEmitErr) ||
                          (state_q == tcd_pkg::StEmitLast && ax_end))) begin
      // final transfer of a trajectory empties the stream
      n_q    <= '0;
      eidx_q <= '0;
      ax_q   <= '0;
    end else begin
      if (take) ax_q <= ax_end ? '0 : ax_q + 1'b1;
      if (take && ax_end && ((state_q == tcd_pkg::StEmitPrev) ||
                             (state_q == tcd_pkg::StEmitTail))) begin
        eidx_q <= eidx_q + 1'b1;
      end
      if (state_q == tcd_pkg::StShift && n_q != 2'd3) n_q <= n_q + 1'b1;
    end
  end

  // point capture, lane results and window shift
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int a = 0; a < NumAxes; a++) begin
        pin_q[a]  <= pin_w[a];
        vnew_q[a] <= '0;
      end
      ft_q      <= ft_w;
      last_q    <= in_i.data.last_point;
      acc_use_q <= (n_q == 2'd3);
    end
    if (state_q == tcd_pkg::StVelWait && busy == '0) begin
      for (int a = 0; a < NumAxes; a++) vnew_q[a] <= rate[a];
    end
    if (state_q == tcd_pkg::StShift) begin
      tw_q[0] <= tw_q[1];
      tw_q[1] <= tw_q[2];
      tw_q[2] <= ft_q;
      for (int a = 0; a < NumAxes; a++) begin
        pw_q[0][a] <= pw_q[1][a];
        pw_q[1][a] <= pw_q[2][a];
        pw_q[2][a] <= pin_q[a];
        vw_q[0][a] <= vw_q[1][a];
        vw_q[1][a] <= vnew_q[a];
      end
      acc_use_q <= (n_q >= 2'd2);
    end
  end

  tcd_merge #(
    .NumAxes (NumAxes)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .item_i (item),
    .rate_i (rate),
    .take_o (take),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  // lanes are started only when all of them are free
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> (busy == '0)) else $error("lane started while busy");

  // emitted axis never reaches the axis count
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> (ax_q < na)) else $error("axis counter out of range");

  // the final result of a trajectory empties the stream
  a_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item.last_result) |=> (n_q == 2'd0 && eidx_q == '0))
    else $error("stream not cleared after final result");

  // no point is taken while a result is being assembled
  a_no_accept_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> !accept) else $error("point accepted during emission");
`endif

endmodule
